// File: rtl/ttc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared widths, codes, state encoding and control structs of the tick
// comparator.
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int WORD_W    = 64;
  localparam int HALF_W    = 32;
  localparam int OP_W      = 2;
  localparam int DIGIT_W   = 4;
  localparam int ADD_STEPS = WORD_W / DIGIT_W;
  localparam int ADD_CNT_W = $clog2(ADD_STEPS);
  localparam int MUL_STEPS = HALF_W;
  localparam int DIV_STEPS = WORD_W;
  localparam int MD_CNT_W  = $clog2(DIV_STEPS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;

  typedef enum logic [OP_W-1:0] {
    OP_ARM      = 2'd0,
    OP_TICK     = 2'd1,
    OP_SUPPRESS = 2'd2,
    OP_RESUME   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MUL,
    ST_DIFF,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic sub;
  } add_ctl_t;

  typedef struct packed {
    logic start;
    logic div;
  } md_ctl_t;

endpackage

// File: rtl/ttc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_if
// Valid/ready channel interfaces of the tick comparator: request input,
// result output and interval configuration.
// ----------------------------------------------------------------------------
interface ttc_in_if;
  import ttc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [HALF_W-1:0] ticks;
  logic [WORD_W-1:0] now;

  modport source (output valid, output operation, output ticks, output now, input ready);
  modport sink   (input valid, input operation, input ticks, input now, output ready);
endinterface

interface ttc_out_if;
  import ttc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] deadline;
  logic [HALF_W-1:0] elapsed;
  logic              kernel_tick;

  modport source (output valid, output deadline, output elapsed, output kernel_tick,
                  input ready);
  modport sink   (input valid, input deadline, input elapsed, input kernel_tick,
                  output ready);
endinterface

interface ttc_cfg_if;
  import ttc_pkg::*;

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] tick_interval;

  modport source (output valid, output tick_interval, input ready);
  modport sink   (input valid, input tick_interval, output ready);
endinterface

// File: rtl/ttc_serial_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_serial_adder
// Digit-serial 64-bit adder/subtractor: one 4-bit digit per cycle, LSB first,
// with a registered done pulse and carry out (no borrow on subtract).
// ----------------------------------------------------------------------------
module ttc_serial_adder (
  input  logic              clk,
  input  logic              rst_n,
  input  ttc_pkg::add_ctl_t ctl,
  input  ttc_pkg::word_t    a,
  input  ttc_pkg::word_t    b,
  output ttc_pkg::word_t    sum,
  output logic              carry,
  output logic              done
);
  import ttc_pkg::*;

  word_t                a_r;
  word_t                b_r;
  logic                 carry_r;
  logic [ADD_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIGIT_W:0]     dsum;

  assign dsum = {1'b0, a_r[DIGIT_W-1:0]} + {1'b0, b_r[DIGIT_W-1:0]}
              + {{DIGIT_W{1'b0}}, carry_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == ADD_CNT_W'(ADD_STEPS - 1));
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ADD_CNT_W'(ADD_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r     <= a;
      b_r     <= ctl.sub ? ~b : b;
      carry_r <= ctl.sub;
    end else if (busy_r) begin
      a_r     <= {dsum[DIGIT_W-1:0], a_r[WORD_W-1:DIGIT_W]};
      b_r     <= b_r >> DIGIT_W;
      carry_r <= dsum[DIGIT_W];
    end
  end

  assign sum   = a_r;
  assign carry = carry_r;
  assign done  = done_r;

endmodule

// File: rtl/ttc_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_muldiv
// Bit-serial unit: 32x32 shift-add multiply (one multiplier bit per cycle)
// and 64/32 restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module ttc_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  ttc_pkg::md_ctl_t ctl,
  input  ttc_pkg::half_t   ivl,
  input  ttc_pkg::word_t   opnd,
  output ttc_pkg::word_t   result,
  output logic             done
);
  import ttc_pkg::*;

  half_t               acc_r;
  word_t               sh_r;
  logic                div_r;
  logic [MD_CNT_W-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [MD_CNT_W-1:0] last;
  logic [HALF_W:0]     mul_sum;
  logic [HALF_W:0]     div_part;
  logic [HALF_W:0]     div_diff;
  logic                div_ge;

  always_comb begin
    mul_sum  = {1'b0, acc_r} + (sh_r[0] ? {1'b0, ivl} : '0);
    div_part = {acc_r, sh_r[WORD_W-1]};
    div_ge   = div_part >= {1'b0, ivl};
    div_diff = div_part - {1'b0, ivl};
    last     = div_r ? MD_CNT_W'(DIV_STEPS - 1) : MD_CNT_W'(MUL_STEPS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      div_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == last);
      if (ctl.start) begin
        busy_r <= 1'b1;
        div_r  <= ctl.div;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= '0;
      sh_r  <= ctl.div ? opnd : {{HALF_W{1'b0}}, opnd[HALF_W-1:0]};
    end else if (busy_r) begin
      if (div_r) begin
        acc_r <= div_ge ? div_diff[HALF_W-1:0] : div_part[HALF_W-1:0];
        sh_r  <= {sh_r[WORD_W-2:0], div_ge};
      end else begin
        acc_r <= mul_sum[HALF_W:1];
        sh_r  <= {sh_r[WORD_W-1:HALF_W], mul_sum[0], sh_r[HALF_W-1:1]};
      end
    end
  end

  assign result = div_r ? sh_r : {acc_r, sh_r[HALF_W-1:0]};
  assign done   = done_r;

endmodule

// File: rtl/tickless_tick_comparator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tickless_tick_comparator
// Keeps a 64-bit compare deadline on a grid of tick intervals and handles
// arm, tick, idle-window suppress and resume requests.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch writes tick_interval and is always ready. The user must write it
//   only while the block is idle, which the block itself does not enforce.
//   in_ch takes one request transaction (operation, ticks, now); out_ch gives
//   one result transaction (deadline, elapsed, kernel_tick) per request.
//   Zero interval disables arm, tick and windows. One request is worked on
//   at a time, through a 4-bit-digit serial adder and a bit-serial
//   multiply/divide unit. Arm and tick take one add; suppress a multiply,
//   then an add; resume a subtract, then divide, multiply and add as needed.
//   A request that starts no arithmetic goes straight to the result.
//   The next request is accepted the cycle after the result is registered.
//   A stalled receiver holds the result in the output register; the block
//   still accepts the next request and stops only once that result is ready.
//   Reset (rst_n low, synchronous) clears the interval, deadline, window base
//   and planned ticks, and empties the output register.
// ----------------------------------------------------------------------------
module tickless_tick_comparator (
  input logic clk,
  input logic rst_n,
  ttc_in_if.sink    in_ch,
  ttc_out_if.source out_ch,
  ttc_cfg_if.sink   cfg_ch
);
  import ttc_pkg::*;

  state_t   state_r, state_nxt;
  op_t      op_r, op_nxt;
  half_t    ivl_r;
  word_t    deadline_r, deadline_nxt;
  word_t    base_r, base_nxt;
  half_t    planned_r, planned_nxt;
  half_t    elapsed_r, elapsed_nxt;
  logic     ktick_r, ktick_nxt;
  logic     out_valid_r, out_valid_nxt;
  word_t    out_deadline_r, out_deadline_nxt;
  half_t    out_elapsed_r, out_elapsed_nxt;
  logic     out_ktick_r, out_ktick_nxt;
  logic     in_ready;

  add_ctl_t add_ctl;
  word_t    add_a;
  word_t    add_b;
  word_t    add_sum;
  logic     add_carry;
  logic     add_done;

  md_ctl_t  md_ctl;
  word_t    md_opnd;
  word_t    md_result;
  logic     md_done;

  word_t    ivl_w;
  logic     ivl_zero;
  half_t    limit;
  logic     q_ge;
  half_t    count;
  op_t      in_op;

  ttc_serial_adder u_add (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (add_ctl),
    .a     (add_a),
    .b     (add_b),
    .sum   (add_sum),
    .carry (add_carry),
    .done  (add_done)
  );

  ttc_muldiv u_md (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (md_ctl),
    .ivl    (ivl_r),
    .opnd   (md_opnd),
    .result (md_result),
    .done   (md_done)
  );

  always_comb begin
    ivl_w    = {{HALF_W{1'b0}}, ivl_r};
    ivl_zero = (ivl_r == '0);
    in_op    = op_t'(in_ch.operation);
    limit    = planned_r - 1'b1;
    q_ge     = (md_result[WORD_W-1:HALF_W] != '0) || (md_result[HALF_W-1:0] >= limit);
    count    = q_ge ? limit : md_result[HALF_W-1:0] + 1'b1;
  end

  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    deadline_nxt     = deadline_r;
    base_nxt         = base_r;
    planned_nxt      = planned_r;
    elapsed_nxt      = elapsed_r;
    ktick_nxt        = ktick_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_deadline_nxt = out_deadline_r;
    out_elapsed_nxt  = out_elapsed_r;
    out_ktick_nxt    = out_ktick_r;
    in_ready         = 1'b0;
    add_ctl          = '0;
    add_a            = base_r;
    add_b            = md_result;
    md_ctl           = '0;
    md_opnd          = add_sum;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt      = in_op;
          elapsed_nxt = '0;
          ktick_nxt   = 1'b0;
          state_nxt   = ST_DONE;
          unique case (in_op)
            OP_ARM: begin
              if (!ivl_zero) begin
                add_ctl.start = 1'b1;
                add_a         = in_ch.now;
                add_b         = ivl_w;
                state_nxt     = ST_ADD;
              end
            end
            OP_TICK: begin
              if (!ivl_zero) begin
                add_ctl.start = 1'b1;
                add_a         = deadline_r;
                add_b         = ivl_w;
                ktick_nxt     = 1'b1;
                state_nxt     = ST_ADD;
              end
            end
            OP_SUPPRESS: begin
              if (!ivl_zero && (in_ch.ticks > HALF_W'(1))) begin
                base_nxt     = deadline_r;
                planned_nxt  = in_ch.ticks;
                md_ctl.start = 1'b1;
                md_opnd      = {{HALF_W{1'b0}}, in_ch.ticks - 1'b1};
                state_nxt    = ST_MUL;
              end else begin
                planned_nxt = '0;
              end
            end
            OP_RESUME: begin
              if ((planned_r != '0) && !ivl_zero) begin
                add_ctl.start = 1'b1;
                add_ctl.sub   = 1'b1;
                add_a         = in_ch.now;
                add_b         = base_r;
                state_nxt     = ST_DIFF;
              end
            end
          endcase
        end
      end
      ST_ADD: begin
        if (add_done) begin
          deadline_nxt = add_sum;
          state_nxt    = ST_DONE;
        end
      end
      ST_MUL: begin
        if (md_done) begin
          add_ctl.start = 1'b1;
          state_nxt     = ST_ADD;
        end
      end
      ST_DIFF: begin
        if (add_done) begin
          if (!add_carry) begin
            deadline_nxt = base_r;
            state_nxt    = ST_DONE;
          end else begin
            md_ctl.start = 1'b1;
            md_ctl.div   = 1'b1;
            state_nxt    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (md_done) begin
          elapsed_nxt = count;
          if (count != limit) begin
            md_ctl.start = 1'b1;
            md_opnd      = {{HALF_W{1'b0}}, count};
            state_nxt    = ST_MUL;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt    = 1'b1;
          out_deadline_nxt = deadline_r;
          out_elapsed_nxt  = elapsed_r;
          out_ktick_nxt    = ktick_r;
          if (op_r == OP_RESUME) begin
            planned_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_ARM;
      ivl_r       <= '0;
      deadline_r  <= '0;
      base_r      <= '0;
      planned_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      deadline_r  <= deadline_nxt;
      base_r      <= base_nxt;
      planned_r   <= planned_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        ivl_r <= cfg_ch.tick_interval;
      end
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r      <= elapsed_nxt;
    ktick_r        <= ktick_nxt;
    out_deadline_r <= out_deadline_nxt;
    out_elapsed_r  <= out_elapsed_nxt;
    out_ktick_r    <= out_ktick_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.deadline    = out_deadline_r;
  assign out_ch.elapsed     = out_elapsed_r;
  assign out_ch.kernel_tick = out_ktick_r;

endmodule

// File: bench/tb_tickless_tick_comparator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tickless_tick_comparator
// Self-checking bench for the tick comparator. A scoreboard class keeps its
// own copy of the interval, deadline and idle window, predicts each result
// from the accepted request and checks the result stream in order. Stimulus
// is a directed pass over the special cases, then random request sequences
// under several intervals and backpressure patterns.
// ----------------------------------------------------------------------------
module tb_tickless_tick_comparator;
  import ttc_pkg::*;

  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_CYCLES     = 400;
  localparam int ITEMS_PER_PHASE = 133;
  localparam int SETTLE_CYCLES   = 150;

  typedef struct {
    bit [63:0] deadline;
    bit [31:0] elapsed;
    bit        kernel_tick;
  } tick_result_t;

  class deadline_tracker;
    bit [31:0]    interval;
    bit [63:0]    deadline;
    bit [63:0]    base;
    bit [31:0]    planned;
    tick_result_t due_results[$];
    int           errors;

    function void set_interval(bit [31:0] value);
      interval = value;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_request(op_t op, bit [31:0] ticks, bit [63:0] now);
      bit [63:0]    ivl;
      bit [63:0]    limit;
      bit [63:0]    count;
      bit [63:0]    quot;
      tick_result_t res;
      ivl = {32'd0, interval};
      res.elapsed = '0;
      res.kernel_tick = 1'b0;
      case (op)
        OP_ARM: begin
          if (ivl != 0) deadline = now + ivl;
        end
        OP_TICK: begin
          if (ivl != 0) begin
            deadline = deadline + ivl;
            res.kernel_tick = 1'b1;
          end
        end
        OP_SUPPRESS: begin
          if (ivl != 0 && ticks > 32'd1) begin
            base = deadline;
            planned = ticks;
            deadline = base + {32'd0, ticks - 32'd1} * ivl;
          end else begin
            planned = '0;
          end
        end
        default: begin
          if (planned != 0 && ivl != 0) begin
            limit = {32'd0, planned} - 64'd1;
            count = '0;
            if (now >= base) begin
              quot = (now - base) / ivl;
              count = (quot >= limit) ? limit : quot + 64'd1;
            end
            if (count < limit) deadline = base + count * ivl;
            res.elapsed = count[31:0];
          end
          planned = '0;
        end
      endcase
      res.deadline = deadline;
      due_results.push_back(res);
    endfunction

    function void check_result(bit [63:0] dl, bit [31:0] el, bit kt);
      tick_result_t exp_res;
      if (due_results.size() == 0) begin
        $display("%0t unexpected result: deadline %h elapsed %0d kernel_tick %b",
                 $time, dl, el, kt);
        errors++;
        return;
      end
      exp_res = due_results.pop_front();
      if (dl !== exp_res.deadline) begin
        $display("%0t deadline mismatch: expected %h, actual %h", $time,
                 exp_res.deadline, dl);
        errors++;
      end
      if (el !== exp_res.elapsed) begin
        $display("%0t elapsed mismatch: expected %0d, actual %0d", $time,
                 exp_res.elapsed, el);
        errors++;
      end
      if (kt !== exp_res.kernel_tick) begin
        $display("%0t kernel_tick mismatch: expected %b, actual %b", $time,
                 exp_res.kernel_tick, kt);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ttc_in_if  in_ch ();
  ttc_out_if out_ch ();
  ttc_cfg_if cfg_ch ();

  tickless_tick_comparator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  deadline_tracker tracker = new();

  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_request;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.check_result(out_ch.deadline, out_ch.elapsed, out_ch.kernel_tick);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_tickless_tick_comparator: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input op_t op, input bit [31:0] ticks, input bit [63:0] now);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.ticks     <= ticks;
    in_ch.now       <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_request(op, ticks, now);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_interval(input bit [31:0] value);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.tick_interval <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.set_interval(value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_item();
    int        pick;
    op_t       op;
    bit [31:0] ticks;
    bit [63:0] now;
    bit [63:0] grid;
    pick  = $urandom_range(99);
    op    = op_t'($urandom_range(3));
    ticks = $urandom;
    now   = {$urandom, $urandom};
    grid  = {32'd0, $urandom_range(tracker.planned)} * {32'd0, tracker.interval};
    if (pick < 10) begin
      op = op;
    end else if (tracker.planned != 0 && pick < 60) begin
      op = OP_RESUME;
      case ($urandom_range(3))
        0: now = tracker.base + grid;
        1: now = tracker.base + grid + $urandom_range(tracker.interval - 32'd1);
        2: now = tracker.base - $urandom_range(1000, 1);
        default: now = tracker.base + grid - 64'd1;
      endcase
    end else if (pick < 35) begin
      op = OP_ARM;
      if ($urandom_range(1)) now = tracker.deadline + $urandom_range(1000);
    end else if (pick < 70) begin
      op = OP_TICK;
    end else if (pick < 90) begin
      op = OP_SUPPRESS;
      case ($urandom_range(9))
        0: ticks = $urandom;
        1: ticks = $urandom_range(1);
        default: ticks = $urandom_range(12, 2);
      endcase
    end else begin
      op = OP_RESUME;
    end
    send_request(op, ticks, now);
  endtask

  initial begin
    bit [31:0] ivl;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.operation      <= OP_ARM;
    in_ch.ticks          <= '0;
    in_ch.now            <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.tick_interval <= '0;
    hold_request = 1'b0;
    tx_idle_pct  = 13;
    rx_idle_pct  = 87;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_interval(32'd0);
    send_request(OP_ARM, 32'd0, 64'h123);
    send_request(OP_TICK, 32'd0, 64'd0);
    send_request(OP_SUPPRESS, 32'd5, 64'd0);
    send_request(OP_RESUME, 32'd0, {$urandom, $urandom});
    drain();

    write_interval(32'd100);
    send_request(OP_ARM, 32'd0, 64'd1000);
    send_request(OP_TICK, 32'd0, 64'd0);
    send_request(OP_SUPPRESS, 32'd0, 64'd0);
    send_request(OP_SUPPRESS, 32'd1, 64'd0);
    send_request(OP_RESUME, 32'd0, 64'd5000);
    send_request(OP_SUPPRESS, 32'd5, 64'd0);
    send_request(OP_RESUME, 32'd0, 64'd0);
    send_request(OP_SUPPRESS, 32'd5, 64'd0);
    send_request(OP_RESUME, 32'd0, 64'd1450);
    send_request(OP_SUPPRESS, 32'd4, 64'd0);
    send_request(OP_RESUME, 32'd0, '1);
    send_request(OP_SUPPRESS, 32'd10, 64'd0);
    drain();

    write_interval(32'd0);
    send_request(OP_RESUME, 32'd0, 64'd5000);
    drain();

    write_interval(32'hFFFF_FFFF);
    send_request(OP_ARM, 32'd0, '1);
    send_request(OP_TICK, '1, '1);
    send_request(OP_SUPPRESS, 32'hFFFF_FFFF, '1);
    send_request(OP_RESUME, '1, '1);
    drain();

    write_interval(32'd1);
    send_request(OP_SUPPRESS, 32'hFFFF_FFFF, 64'd0);
    send_request(OP_RESUME, 32'd0, '1);
    send_request(OP_RESUME, '1, 64'd0);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase / 3)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct = 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 13;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (phase)
        0: ivl = 32'd1;
        1: ivl = $urandom_range(1000, 2);
        2: ivl = 32'hFFFF_FFFF;
        3: ivl = $urandom;
        4: ivl = 32'd0;
        5: ivl = 32'd3;
        6: ivl = $urandom_range(64, 2);
        7: ivl = 32'hFFFF_FFFF;
        default: ivl = $urandom;
      endcase
      write_interval(ivl);
      if (phase == 6) hold_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) drain();
        send_random_item();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending() != 0) begin
      $display("%0t %0d expected results never arrived", $time, tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("tb_tickless_tick_comparator: clean");
    end else begin
      $display("tb_tickless_tick_comparator: errors");
    end
    $finish;
  end

endmodule
